// File: src/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, operation codes, state encoding and the control/status
// bundles of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int MAX_BITS   = 4096;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = MAX_BITS / WORD_BITS;
  localparam int IDX_W      = $clog2(MAX_BITS);
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = IDX_W - OFF_W;
  localparam int CNT_W      = IDX_W + 1;

  // full-flag search: groups of words, group summary bits are registered
  localparam int GRP_SIZE   = 8;
  localparam int GRP_COUNT  = NUM_WORDS / GRP_SIZE;
  localparam int GSEL_W     = $clog2(GRP_SIZE);
  localparam int GRP_W      = $clog2(GRP_COUNT);

  localparam int OP_W       = 2;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX          = CNT_W'(MAX_BITS);
  localparam logic [CFG_AW-1:0] ADDR_BITS_IN_USE = CFG_AW'(0);

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2,
    OP_ALLOC = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_MODIFY,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic load;    // input beat taken, read of the addressed word issued
    logic find;    // pick first non-full word, read it
    logic modify;  // update word and flags, latch result
    logic emit;    // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_alloc;
    logic out_free;
  } status_t;

endpackage

// File: src/bsa_in_if.sv
// ----------------------------------------------------------------------------
// bsa_in_if
// Request channel: operation code and bit index, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsa_in_if;
  import bsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   bit_index;

  modport source (output valid, output operation, output bit_index, input ready);
  modport sink   (input valid, input operation, input bit_index, output ready);

endinterface

// File: src/bsa_out_if.sv
// ----------------------------------------------------------------------------
// bsa_out_if
// Result channel: test bit, allocation flag and index, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsa_out_if;
  import bsa_pkg::*;

  logic               valid;
  logic               ready;
  logic               bit_is_set;
  logic               alloc_found;
  logic [IDX_W-1:0]   alloc_index;

  modport source (output valid, output bit_is_set, output alloc_found,
                  output alloc_index, input ready);
  modport sink   (input valid, input bit_is_set, input alloc_found,
                  input alloc_index, output ready);

endinterface

// File: src/bitmap_slot_allocator_core.sv
// Set/clear/test pass through the accept, read-modify-write and emit steps
// of the sequencer; allocate adds a free-word search step before the
// read-modify-write. A new input beat is taken only while the sequencer is
// idle, so one request is handled at a time; a result waiting in the output
// register does not block the next input beat. Synchronous active-low reset
// clears the bitmap at once through per-word valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core
// Bitmap allocator with set, clear, test and find-first-zero allocate,
// bit count programmed over an APB register.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  bsa_in_if.sink                     in_if,
  bsa_out_if.source                  out_if,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bsa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bsa_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bsa_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import bsa_pkg::*;

  cmd_t             cmd;
  status_t          sts;
  logic             out_free;
  logic             in_ready;
  logic [CNT_W-1:0] bits_in_use;

  assign sts.in_valid = in_if.valid;
  assign sts.in_alloc = (in_if.operation == OP_ALLOC);
  assign sts.out_free = out_free;
  assign in_if.ready  = in_ready;

  bsa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .bits_in_use (bits_in_use)
  );

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  bsa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .out_free        (out_free),
    .in_operation    (in_if.operation),
    .in_bit_index    (in_if.bit_index),
    .bits_in_use     (bits_in_use),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_bit_is_set  (out_if.bit_is_set),
    .out_alloc_found (out_if.alloc_found),
    .out_alloc_index (out_if.alloc_index)
  );

endmodule

// File: src/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bsa_cfg.sv
// ----------------------------------------------------------------------------
// bsa_cfg
// APB register slice holding the managed bit count.
// ----------------------------------------------------------------------------
module bsa_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsa_pkg::CFG_AW-1:0] paddr,
  input  logic [bsa_pkg::CFG_DW-1:0] pwdata,
  output logic [bsa_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output logic [bsa_pkg::CNT_W-1:0]  bits_in_use
);
  import bsa_pkg::*;

  logic [CNT_W-1:0] bits_r;
  logic             wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == ADDR_BITS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= CNT_MAX;
    end else if (wr_hit) begin
      bits_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_BITS_IN_USE) begin
      prdata = CFG_DW'(bits_r);
    end
  end

  assign bits_in_use = bits_r;

endmodule

// File: src/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer: accept, optional free-word search, read-modify-write, emit.
// ----------------------------------------------------------------------------
module bsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  bsa_pkg::status_t sts,
  output bsa_pkg::cmd_t    cmd,
  output logic             in_ready
);
  import bsa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_nxt = sts.in_alloc ? ST_FIND : ST_MODIFY;
        end
      end
      ST_FIND:   state_nxt = ST_MODIFY;
      ST_MODIFY: state_nxt = ST_OUTPUT;
      ST_OUTPUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = sts.in_valid;
      end
      ST_FIND:   cmd.find   = 1'b1;
      ST_MODIFY: cmd.modify = 1'b1;
      ST_OUTPUT: cmd.emit   = sts.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

// File: src/bsa_dp.sv
// ----------------------------------------------------------------------------
// bsa_dp
// Bitmap datapath: word RAM with per-word valid and full flags, free-word
// search, bit update and the result/output registers.
// ----------------------------------------------------------------------------
module bsa_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bsa_pkg::cmd_t             cmd,
  output logic                      out_free,
  input  logic [bsa_pkg::OP_W-1:0]  in_operation,
  input  logic [bsa_pkg::IDX_W-1:0] in_bit_index,
  input  logic [bsa_pkg::CNT_W-1:0] bits_in_use,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_bit_is_set,
  output logic                      out_alloc_found,
  output logic [bsa_pkg::IDX_W-1:0] out_alloc_index
);
  import bsa_pkg::*;

  function automatic logic [OFF_W-1:0] first_zero_word(input logic [WORD_BITS-1:0] w);
    logic [OFF_W-1:0] p;
    p = OFF_W'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) p = OFF_W'(i);
    end
    return p;
  endfunction

  function automatic logic [GRP_W-1:0] first_grp(input logic [GRP_COUNT-1:0] v);
    logic [GRP_W-1:0] p;
    p = '0;
    for (int i = GRP_COUNT - 1; i >= 0; i--) begin
      if (v[i]) p = GRP_W'(i);
    end
    return p;
  endfunction

  function automatic logic [GSEL_W-1:0] first_in_grp(input logic [GRP_SIZE-1:0] v);
    logic [GSEL_W-1:0] p;
    p = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) p = GSEL_W'(i);
    end
    return p;
  endfunction

  // request registers
  op_t                  op_r;
  logic [IDX_W-1:0]     idx_r;

  // word flags
  logic [NUM_WORDS-1:0]  word_vld_r;
  logic [NUM_WORDS-1:0]  full_r;
  logic [GRP_COUNT-1:0]  grp_free_r;
  logic [GRP_COUNT-1:0]  grp_free_nxt;

  // read side
  logic [WADDR_W-1:0]   raddr;
  logic [WADDR_W-1:0]   raddr_r;
  logic                 rd_vld_r;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 any_free_r;

  // search
  logic [GRP_W-1:0]     grp_sel;
  logic [GSEL_W-1:0]    word_sel;

  // modify
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] bit_mask;
  logic [CNT_W-1:0]     eff_cnt;
  logic [OFF_W-1:0]     zero_pos;
  logic [IDX_W-1:0]     cand;
  logic                 in_range;
  logic                 wr_en;
  logic                 is_set;
  logic                 found;

  // result and output registers
  logic                 res_set_r;
  logic                 res_found_r;
  logic [IDX_W-1:0]     res_index_r;
  logic                 out_valid_r;
  logic                 out_set_r;
  logic                 out_found_r;
  logic [IDX_W-1:0]     out_index_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      idx_r <= in_bit_index;
    end
  end

  // group summary is registered from full_r and follows it in the next cycle; full_r changes only in
  // the modify step, which is always followed by output and idle cycles
  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_free_nxt[g] = ~&full_r[g*GRP_SIZE +: GRP_SIZE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_free_r <= '1;
    end else begin
      grp_free_r <= grp_free_nxt;
    end
  end

  assign grp_sel  = first_grp(grp_free_r);
  assign word_sel = first_in_grp(~full_r[{grp_sel, GSEL_W'(0)} +: GRP_SIZE]);

  assign raddr = cmd.find ? {grp_sel, word_sel} : in_bit_index[IDX_W-1:OFF_W];

  always_ff @(posedge clk) begin
    raddr_r  <= raddr;
    rd_vld_r <= word_vld_r[raddr];
    if (cmd.find) begin
      any_free_r <= |grp_free_r;
    end
  end

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_words (
    .clk   (clk),
    .we    (wr_en),
    .waddr (raddr_r),
    .wdata (new_word),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // a word never written reads as all free
  assign word     = rd_vld_r ? ram_rdata : '0;
  assign eff_cnt  = (bits_in_use > CNT_MAX) ? CNT_MAX : bits_in_use;
  assign zero_pos = first_zero_word(word);
  assign cand     = {raddr_r, zero_pos};
  assign in_range = {1'b0, idx_r} < eff_cnt;

  always_comb begin
    bit_mask = '0;
    new_word = word;
    wr_en    = 1'b0;
    is_set   = 1'b0;
    found    = 1'b0;
    case (op_r)
      OP_SET: begin
        bit_mask[idx_r[OFF_W-1:0]] = 1'b1;
        new_word = word | bit_mask;
        wr_en    = cmd.modify && in_range;
      end
      OP_CLEAR: begin
        bit_mask[idx_r[OFF_W-1:0]] = 1'b1;
        new_word = word & ~bit_mask;
        wr_en    = cmd.modify && in_range;
      end
      OP_TEST: begin
        is_set = in_range && word[idx_r[OFF_W-1:0]];
      end
      OP_ALLOC: begin
        bit_mask[zero_pos] = 1'b1;
        new_word = word | bit_mask;
        found    = any_free_r && ({1'b0, cand} < eff_cnt);
        wr_en    = cmd.modify && found;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= '0;
      full_r     <= '0;
    end else if (wr_en) begin
      word_vld_r[raddr_r] <= 1'b1;
      full_r[raddr_r]     <= &new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      res_set_r   <= is_set;
      res_found_r <= found;
      res_index_r <= found ? cand : '0;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_set_r   <= res_set_r;
      out_found_r <= res_found_r;
      out_index_r <= res_index_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_is_set  = out_set_r;
  assign out_alloc_found = out_found_r;
  assign out_alloc_index = out_index_r;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap slot allocator: directed set/clear/
// test/alloc beats, bit count edges over APB, a long output hold-off and
// random traffic under four idle/stall phases, all scored against a
// cycle-free model of the bitmap.
// ----------------------------------------------------------------------------
module tb_top;
  import bsa_pkg::*;

  typedef struct packed {
    logic             bit_is_set;
    logic             alloc_found;
    logic [IDX_W-1:0] alloc_index;
  } slot_result_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  bsa_in_if  in_bus ();
  bsa_out_if out_bus ();

  bitmap_slot_allocator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_bus),
    .out_if     (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // model state
  logic [WORD_BITS-1:0] shadow_words [NUM_WORDS];
  logic [CNT_W-1:0]     shadow_count;
  slot_result_t         expected_slots [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  logic hold_rx    = 1'b0;

  int mismatch_count  = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int allocs_granted  = 0;
  int count_writes    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", expected_slots.size());
    $display("status: fail");
    $finish;
  end

  function automatic slot_result_t predict_slot_op(op_t op, logic [IDX_W-1:0] idx);
    slot_result_t res;
    int eff;
    int wi;
    int p;
    int cand;
    res = '0;
    eff = (shadow_count > CNT_MAX) ? MAX_BITS : int'(shadow_count);
    if (op == OP_ALLOC) begin
      // first non-full word; if its lowest hole is past the count, so is every later one
      for (wi = 0; wi < NUM_WORDS && !res.alloc_found; wi++) begin
        if (shadow_words[wi] != '1) begin
          p = 0;
          while (p < WORD_BITS - 1 && shadow_words[wi][p]) p++;
          cand = wi * WORD_BITS + p;
          if (cand < eff) begin
            shadow_words[wi][p] = 1'b1;
            res.alloc_found = 1'b1;
            res.alloc_index = IDX_W'(cand);
          end
        end
      end
    end else if (int'(idx) < eff) begin
      wi = int'(idx) / WORD_BITS;
      p  = int'(idx) % WORD_BITS;
      case (op)
        OP_SET:   shadow_words[wi][p] = 1'b1;
        OP_CLEAR: shadow_words[wi][p] = 1'b0;
        default:  res.bit_is_set = shadow_words[wi][p];
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // one request beat; valid stays up after the beat unless the next call idles or drain_results lowers it
  task automatic send_slot_op(op_t op, logic [IDX_W-1:0] idx);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.bit_index <= idx;
    do @(posedge clk); while (!in_bus.ready);
    expected_slots.push_back(predict_slot_op(op, idx));
    requests_sent++;
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    // margin past the alloc latency before touching the register
    repeat (8) @(posedge clk);
  endtask

  task automatic program_bit_count(int unsigned value);
    logic [CNT_W-1:0] written;
    written = value[CNT_W-1:0];
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_BITS_IN_USE;
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_count = written;
    count_writes++;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(written))
      report_mismatch("bits_in_use readback", int'(cfg_prdata), int'(written));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // result scoreboard
  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_slots.size() == 0) begin
        report_mismatch("unexpected result beat, alloc_index", int'(out_bus.alloc_index), -1);
      end else begin
        want = expected_slots.pop_front();
        results_checked++;
        if (want.alloc_found) allocs_granted++;
        if (out_bus.bit_is_set !== want.bit_is_set)
          report_mismatch("bit_is_set", int'(out_bus.bit_is_set), int'(want.bit_is_set));
        if (out_bus.alloc_found !== want.alloc_found)
          report_mismatch("alloc_found", int'(out_bus.alloc_found), int'(want.alloc_found));
        if (out_bus.alloc_index !== want.alloc_index)
          report_mismatch("alloc_index", int'(out_bus.alloc_index), int'(want.alloc_index));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_rx)
      out_bus.ready <= 1'b0;
    else
      out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic test_basic_ops();
    send_slot_op(OP_ALLOC, '0);
    send_slot_op(OP_ALLOC, '1);
    send_slot_op(OP_SET,   IDX_W'(2));
    send_slot_op(OP_ALLOC, IDX_W'(2));
    send_slot_op(OP_SET,   '1);
    send_slot_op(OP_TEST,  '1);
    send_slot_op(OP_TEST,  IDX_W'(MAX_BITS - 2));
    send_slot_op(OP_CLEAR, IDX_W'(1));
    send_slot_op(OP_ALLOC, '0);
    send_slot_op(OP_CLEAR, '1);
    send_slot_op(OP_TEST,  '1);
    send_slot_op(OP_TEST,  IDX_W'(2));
  endtask

  task automatic test_count_edges();
    // single managed bit, already taken
    program_bit_count(1);
    send_slot_op(OP_ALLOC, '0);
    send_slot_op(OP_TEST,  IDX_W'(2));
    send_slot_op(OP_CLEAR, '0);
    send_slot_op(OP_ALLOC, '0);
    send_slot_op(OP_SET,   IDX_W'(3));
    // nothing managed
    program_bit_count(0);
    send_slot_op(OP_TEST,  '0);
    send_slot_op(OP_ALLOC, '0);
    send_slot_op(OP_CLEAR, '0);
    // above the maximum: saturates, old bits reachable again
    program_bit_count((1 << CNT_W) - 1);
    send_slot_op(OP_TEST,  '0);
    send_slot_op(OP_TEST,  IDX_W'(3));
    send_slot_op(OP_SET,   '1);
    send_slot_op(OP_TEST,  '1);
    send_slot_op(OP_ALLOC, '0);
    drain_results();
  endtask

  task automatic test_backpressure();
    rx_stall_pct <= 0;
    tx_idle_pct = 0;
    program_bit_count(64);
    fork
      begin
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
      end
      begin
        repeat (16) send_slot_op(OP_ALLOC, IDX_W'($urandom_range(MAX_BITS - 1)));
      end
    join
    drain_results();
  endtask

  task automatic test_random();
    int unsigned count_picks [8] = '{32, 33, 64, 100, MAX_BITS, 0, (1 << CNT_W) - 1, 1};
    int unsigned lead_counts [4] = '{MAX_BITS, 1, 33, (1 << CNT_W) - 1};
    int tx_pcts [4] = '{0, 53, 0, 23};
    int rx_pcts [4] = '{0, 0, 53, 23};
    int unsigned pick;
    int lim;
    int r;
    op_t op;
    logic [IDX_W-1:0] idx;
    for (int phase = 0; phase < 4; phase++) begin
      for (int s = 0; s < 4; s++) begin
        if (s == 0) pick = lead_counts[phase];
        else if ($urandom_range(3) == 0) pick = $urandom_range(MAX_BITS, 1);
        else pick = count_picks[$urandom_range(7)];
        program_bit_count(pick);
        rx_stall_pct <= rx_pcts[phase];
        tx_idle_pct = tx_pcts[phase];
        lim = (pick > MAX_BITS) ? MAX_BITS - 1 : int'(pick) + 7;
        if (lim > MAX_BITS - 1) lim = MAX_BITS - 1;
        for (int n = 0; n < 78; n++) begin
          r = $urandom_range(99);
          op = (r < 35) ? OP_ALLOC : (r < 60) ? OP_CLEAR : (r < 80) ? OP_SET : OP_TEST;
          // mostly near the managed range, some anywhere
          if ($urandom_range(99) < 15) idx = IDX_W'($urandom_range(MAX_BITS - 1));
          else idx = IDX_W'($urandom_range(lim));
          send_slot_op(op, idx);
        end
      end
    end
    rx_stall_pct <= 0;
    tx_idle_pct = 0;
    drain_results();
  endtask

  initial begin
    foreach (shadow_words[i]) shadow_words[i] = '0;
    shadow_count = CNT_MAX;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_SET;
    in_bus.bit_index <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_count_edges();
    test_backpressure();
    test_random();

    drain_results();
    repeat (10) @(posedge clk);
    $display("summary: %0d requests, %0d results scored, %0d allocs granted",
             requests_sent, results_checked, allocs_granted);
    $display("summary: %0d bit count writes, four idle/stall phases, one 400-cycle hold-off",
             count_writes);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bsa_pkg.sv
src/bsa_in_if.sv
src/bsa_out_if.sv
src/bsa_ram.sv
src/bsa_cfg.sv
src/bsa_ctrl.sv
src/bsa_dp.sv
src/bitmap_slot_allocator_core.sv
bench/tb_top.sv
